[rtl/thick_line_rasterizer_defines.svh]
// Assertion macros for the checker file of the thick line rasterizer.
// Needs nothing else; the including file supplies clk and rst.
`ifndef THICK_LINE_RASTERIZER_DEFINES_SVH
`define THICK_LINE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the trigger.
`define TLR_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("tlr check failed");

// The consequent must hold in the cycle after the trigger.
`define TLR_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("tlr check failed");

`endif

[rtl/tlr_pkg.sv]
// Shared types and constants of the thick line rasterizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package tlr_pkg;

  localparam int DISPLAY_WIDTH  = 64;
  localparam int DISPLAY_HEIGHT = 128;
  localparam int COORD_W = 8;
  localparam int ERR_W   = 11;
  localparam int THICK_W = 6;
  localparam int PX_W    = 6;
  localparam int PY_W    = 7;
  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(DISPLAY_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(DISPLAY_HEIGHT - 1);

  // Thickness modes.
  localparam logic [1:0] MODE_CENTER = 2'd0;
  localparam logic [1:0] MODE_CW     = 2'd1;
  localparam logic [1:0] MODE_CCW    = 2'd2;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef enum logic [1:0] {PH_IDLE, PH_START, PH_RUN, PH_MINOR} tlr_phase_t;

  typedef enum logic [2:0] {ST_WAIT, ST_SETUP, ST_ADJ, ST_NEXT, ST_BEGIN} tlr_state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic outer_step;
    logic negate;
    logic reinit;
    logic begin_line;
    logic step;
  } tlr_ctl_t;

  typedef struct packed {
    logic thin;
    logic adj_zero;
    logic need_next;
  } tlr_status_t;

endpackage

[rtl/thick_line_rasterizer.sv]
// Pixel request: result registered, shown in the cycle after the beat; one per cycle
// while out_ready drains it; the next parallel line first needs a shift, then a line start.
// Load: thin lines: line start only; thick: setup, adjust count (<= 62) steps, line start.
// Reset (rst, synchronous, active high) idles the sequencer and engine; mode to center.
// Depends on tlr_pkg, tlr_ctrl and tlr_datapath.
module thick_line_rasterizer import tlr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [7:0]         x_start,
  input  logic [7:0]         y_start,
  input  logic [7:0]         x_end,
  input  logic [7:0]         y_end,
  input  logic [THICK_W-1:0] thickness,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PX_W-1:0]    pixel_x,
  output logic [PY_W-1:0]    pixel_y,
  output logic               last_pixel,
  output logic               no_pixel
);

  tlr_ctl_t    ctl;
  tlr_status_t sts;

  // Sequencer.
  tlr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Coordinate engine.
  tlr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .thickness  (thickness),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel),
    .no_pixel   (no_pixel)
  );

endmodule

[rtl/tlr_ctrl.sv]
// Controller of the thick line rasterizer: sequences load, shift and step.
// Depends on tlr_pkg.
module tlr_ctrl import tlr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  input  tlr_status_t sts,
  output tlr_ctl_t    ctl
);

  tlr_state_t state, state_next;
  logic       accept;

  assign accept = in_valid & in_ready;

  // A beat is taken only between jobs and when the result slot can drain.
  always_comb begin
    in_ready = (state == ST_WAIT) && (!out_valid || out_ready);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_WAIT: begin
        if (accept && cmd == CMD_LOAD) begin
          state_next = sts.thin ? ST_BEGIN : ST_SETUP;
        end else if (accept && sts.need_next) begin
          state_next = ST_NEXT;
        end
      end
      ST_SETUP: state_next = ST_ADJ;
      ST_ADJ: begin
        if (sts.adj_zero) begin
          state_next = ST_BEGIN;
        end
      end
      ST_NEXT:  state_next = ST_BEGIN;
      ST_BEGIN: state_next = ST_WAIT;
      default:  state_next = ST_WAIT;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl = '0;
    unique case (state)
      ST_WAIT: begin
        ctl.load = accept && cmd == CMD_LOAD;
        ctl.step = accept && cmd == CMD_NEXT;
      end
      ST_SETUP: ctl.setup = 1'b1;
      ST_ADJ: begin
        ctl.outer_step = !sts.adj_zero;
        ctl.negate     = 1'b1;
        ctl.reinit     = sts.adj_zero;
      end
      ST_NEXT:  ctl.outer_step = 1'b1;
      ST_BEGIN: ctl.begin_line = 1'b1;
      default:  ctl = '0;
    endcase
  end

  // State and result slot registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WAIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && cmd == CMD_NEXT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/tlr_datapath.sv]
// Datapath of the thick line rasterizer: endpoints, outer and inner Bresenham
// state and the result register. Depends on tlr_pkg.
module tlr_datapath import tlr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  tlr_ctl_t            ctl,
  output tlr_status_t         sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic [7:0]          x_start,
  input  logic [7:0]          y_start,
  input  logic [7:0]          x_end,
  input  logic [7:0]          y_end,
  input  logic [THICK_W-1:0]  thickness,
  output logic [PX_W-1:0]     pixel_x,
  output logic [PY_W-1:0]     pixel_y,
  output logic                last_pixel,
  output logic                no_pixel
);

  // Saturating one-pixel move.
  function automatic logic [COORD_W-1:0] sat_move(input logic [COORD_W-1:0] v,
                                                  input logic neg,
                                                  input logic [COORD_W-1:0] vmax);
    logic [COORD_W-1:0] r;
    if (neg) r = (v == '0) ? '0 : v - 1'b1;
    else     r = (v >= vmax) ? vmax : v + 1'b1;
    return r;
  endfunction

  // Starting error 2*dmin - dmaj.
  function automatic logic signed [ERR_W-1:0] err_init(input logic [COORD_W-1:0] dmin,
                                                       input logic [COORD_W-1:0] dmaj);
    return $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
  endfunction

  function automatic logic [COORD_W-1:0] clamp(input logic [7:0] v,
                                               input logic [COORD_W-1:0] vmax);
    return (COORD_W'(v) > vmax) ? vmax : COORD_W'(v);
  endfunction

  logic [1:0]               mode;
  logic [COORD_W-1:0]       ep_sx, ep_sy, ep_ex, ep_ey;
  logic [THICK_W-1:0]       thick;
  logic                     o_neg_x, o_neg_y, o_ymaj;
  logic [COORD_W-1:0]       o_dmaj, o_dmin;
  logic signed [ERR_W-1:0]  o_err;
  logic [THICK_W-1:0]       adj_cnt, lines_left;
  logic                     ov_pend;
  logic [COORD_W-1:0]       pos_x, pos_y, i_dx, i_dy;
  logic                     i_negx, i_negy, i_xmaj, i_ovl;
  logic signed [ERR_W-1:0]  i_err;
  tlr_phase_t               phase;

  // Setup of the outer (perpendicular) walk from the clamped endpoints.
  logic signed [COORD_W:0]  dlx, dly;
  logic [COORD_W-1:0]       ddx, ddy, s_dmaj, s_dmin;
  logic                     swap, s_xmaj, s_neg_x, s_neg_y;
  logic [THICK_W-1:0]       adj_base, adj_inv, s_adj;

  always_comb begin
    dlx  = $signed({1'b0, ep_ex}) - $signed({1'b0, ep_sx});
    dly  = $signed({1'b0, ep_ey}) - $signed({1'b0, ep_sy});
    ddx  = dly[COORD_W] ? COORD_W'(-dly) : COORD_W'(dly);
    ddy  = dlx[COORD_W] ? COORD_W'(-dlx) : COORD_W'(dlx);
    swap = ~(dly[COORD_W] ^ dlx[COORD_W]);
    unique case (mode)
      MODE_CCW: adj_base = thick - 1'b1;
      MODE_CW:  adj_base = '0;
      default:  adj_base = thick >> 1;
    endcase
    adj_inv = thick - 1'b1 - adj_base;
    s_xmaj  = ddx >= ddy;
    if (s_xmaj) begin
      s_adj   = swap ? adj_inv : adj_base;
      s_neg_x = dly[COORD_W] ^ ~swap;
      s_neg_y = dlx[COORD_W] ^ swap;
      s_dmaj  = ddx;
      s_dmin  = ddy;
    end else begin
      s_adj   = swap ? adj_base : adj_inv;
      s_neg_x = dly[COORD_W] ^ swap;
      s_neg_y = dlx[COORD_W] ^ ~swap;
      s_dmaj  = ddy;
      s_dmin  = ddx;
    end
  end

  // One outer step: shift along the major shift axis, and along the other on error.
  logic                     e_pos, sh_x, sh_y;
  logic [COORD_W-1:0]       sx_n, ex_n, sy_n, ey_n;
  logic signed [ERR_W-1:0]  o_err_n;

  always_comb begin
    e_pos   = !o_err[ERR_W-1];
    sh_x    = o_ymaj ? e_pos : 1'b1;
    sh_y    = o_ymaj ? 1'b1 : e_pos;
    sx_n    = sh_x ? sat_move(ep_sx, o_neg_x ^ ctl.negate, X_MAX) : ep_sx;
    ex_n    = sh_x ? sat_move(ep_ex, o_neg_x ^ ctl.negate, X_MAX) : ep_ex;
    sy_n    = sh_y ? sat_move(ep_sy, o_neg_y ^ ctl.negate, Y_MAX) : ep_sy;
    ey_n    = sh_y ? sat_move(ep_ey, o_neg_y ^ ctl.negate, Y_MAX) : ep_ey;
    o_err_n = o_err - (e_pos ? $signed({2'b00, o_dmaj, 1'b0}) : '0)
                    + $signed({2'b00, o_dmin, 1'b0});
  end

  // Start of one inner Bresenham line.
  logic signed [COORD_W:0]  bdx, bdy;
  logic [COORD_W-1:0]       b_dx, b_dy;
  logic                     b_xmaj;

  always_comb begin
    bdx    = $signed({1'b0, ep_ex}) - $signed({1'b0, ep_sx});
    bdy    = $signed({1'b0, ep_ey}) - $signed({1'b0, ep_sy});
    b_dx   = bdx[COORD_W] ? COORD_W'(-bdx) : COORD_W'(bdx);
    b_dy   = bdy[COORD_W] ? COORD_W'(-bdy) : COORD_W'(bdy);
    b_xmaj = b_dx > b_dy;
  end

  // One inner step for a pixel request.
  logic                     run, mnr, e_ge, go_minor, do_min, add_mn, mv_x, mv_y, done;
  logic [COORD_W-1:0]       d_mj, d_mn, nx, ny;
  logic signed [ERR_W-1:0]  i_err_n;
  tlr_phase_t               phase_n;

  always_comb begin
    run      = phase == PH_RUN;
    mnr      = phase == PH_MINOR;
    e_ge     = !i_err[ERR_W-1];
    d_mj     = i_xmaj ? i_dx : i_dy;
    d_mn     = i_xmaj ? i_dy : i_dx;
    go_minor = run & e_ge & i_ovl;
    do_min   = (run & e_ge & ~i_ovl) | mnr;
    add_mn   = (run & ~go_minor) | mnr;
    mv_x     = i_xmaj ? run : do_min;
    mv_y     = i_xmaj ? do_min : run;
    nx       = mv_x ? (i_negx ? pos_x - 1'b1 : pos_x + 1'b1) : pos_x;
    ny       = mv_y ? (i_negy ? pos_y - 1'b1 : pos_y + 1'b1) : pos_y;
    i_err_n  = i_err - (do_min ? $signed({2'b00, d_mj, 1'b0}) : '0)
                     + (add_mn ? $signed({2'b00, d_mn, 1'b0}) : '0);
    done     = (phase != PH_IDLE) && !go_minor &&
               ((i_xmaj ? nx : ny) == (i_xmaj ? ep_ex : ep_ey));
    // A request with no line active leaves the engine idle.
    if (phase == PH_IDLE) phase_n = PH_IDLE;
    else if (go_minor) phase_n = PH_MINOR;
    else if (done && lines_left == '0) phase_n = PH_IDLE;
    else phase_n = PH_RUN;
  end

  always_comb begin
    sts.thin      = thickness <= THICK_W'(1);
    sts.adj_zero  = adj_cnt == '0;
    sts.need_next = done && lines_left != '0;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CENTER;
      phase      <= PH_IDLE;
      lines_left <= '0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (ctl.load) begin
        lines_left <= sts.thin ? '0 : thickness - 1'b1;
      end else if (ctl.step && sts.need_next) begin
        lines_left <= lines_left - 1'b1;
      end
      if (ctl.begin_line) begin
        phase <= PH_START;
      end else if (ctl.step) begin
        phase <= phase_n;
      end
    end
  end

  // Endpoints and outer walk.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ep_sx   <= clamp(x_start, X_MAX);
      ep_sy   <= clamp(y_start, Y_MAX);
      ep_ex   <= clamp(x_end, X_MAX);
      ep_ey   <= clamp(y_end, Y_MAX);
      thick   <= thickness;
      ov_pend <= 1'b0;
    end else if (ctl.outer_step) begin
      ep_sx   <= sx_n;
      ep_sy   <= sy_n;
      ep_ex   <= ex_n;
      ep_ey   <= ey_n;
      o_err   <= o_err_n;
      ov_pend <= e_pos;
    end
    if (ctl.outer_step && ctl.negate) begin
      adj_cnt <= adj_cnt - 1'b1;
    end
    if (ctl.setup) begin
      o_neg_x <= s_neg_x;
      o_neg_y <= s_neg_y;
      o_ymaj  <= !s_xmaj;
      o_dmaj  <= s_dmaj;
      o_dmin  <= s_dmin;
      o_err   <= err_init(s_dmin, s_dmaj);
      adj_cnt <= s_adj;
    end
    if (ctl.reinit) begin
      o_err   <= err_init(o_dmin, o_dmaj);
      ov_pend <= 1'b0;
    end
  end

  // Inner line and the result register.
  always_ff @(posedge clk) begin
    if (ctl.begin_line) begin
      pos_x  <= ep_sx;
      pos_y  <= ep_sy;
      i_dx   <= b_dx;
      i_dy   <= b_dy;
      i_negx <= bdx[COORD_W];
      i_negy <= bdy[COORD_W];
      i_xmaj <= b_xmaj;
      i_err  <= b_xmaj ? err_init(b_dy, b_dx) : err_init(b_dx, b_dy);
      i_ovl  <= ov_pend;
    end else if (ctl.step) begin
      pos_x <= nx;
      pos_y <= ny;
      i_err <= i_err_n;
    end
    if (ctl.step) begin
      if (phase == PH_IDLE) begin
        pixel_x    <= '0;
        pixel_y    <= '0;
        last_pixel <= 1'b0;
        no_pixel   <= 1'b1;
      end else begin
        pixel_x    <= nx[PX_W-1:0];
        pixel_y    <= ny[PY_W-1:0];
        last_pixel <= done && lines_left == '0;
        no_pixel   <= 1'b0;
      end
    end
  end

endmodule

[rtl/tlr_checker.sv]
// Port-level checks of the thick line rasterizer, bound to the top level.
// Depends on thick_line_rasterizer_defines.svh.
`include "thick_line_rasterizer_defines.svh"

module tlr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       cmd,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] pixel_x,
  input logic [6:0] pixel_y,
  input logic       last_pixel,
  input logic       no_pixel
);

  // An idle answer carries no coordinates.
  `TLR_ASSERT_NOW(a_idle_zero, out_valid && no_pixel, pixel_x == '0 && pixel_y == '0 && !last_pixel)
  // A final pixel is a real pixel.
  `TLR_ASSERT_NOW(a_last_real, out_valid && last_pixel, !no_pixel)
  // A load beat always occupies the engine and drops in_ready.
  `TLR_ASSERT_NEXT(a_load_busy, in_valid && in_ready && !cmd, !in_ready)
  // A stalled result beat holds.
  `TLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({pixel_x, pixel_y}))

endmodule

bind thick_line_rasterizer tlr_checker u_tlr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .cmd        (cmd),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y),
  .last_pixel (last_pixel),
  .no_pixel   (no_pixel)
);
